>>> hw/rtl/ecmh_pkg.sv
// Package for the erase-count min-heap: field types, heap entry, op and
// status codes, controller states and the memory request/response bundles.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ecmh_pkg;

  localparam int SEG_W   = 10;
  localparam int KEY_W   = 24;
  localparam int POS_W   = 10;
  localparam int CNT_W   = 11;
  localparam int IDX_W   = 3;
  localparam int CHILD_W = POS_W + 2;
  localparam int CAP     = 1024;
  localparam int SEGS    = 1 << SEG_W;

  typedef logic [SEG_W-1:0]   seg_t;
  typedef logic [KEY_W-1:0]   key_t;
  typedef logic [POS_W-1:0]   pos_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [CHILD_W-1:0] child_t;

  localparam key_t KEY_MAX  = '1;
  localparam cnt_t CNT_FULL = cnt_t'(CAP);

  typedef struct packed {
    seg_t seg;
    key_t key;
  } ent_t;

  localparam int ENT_W = $bits(ent_t);

  typedef enum logic [2:0] {
    OP_INSERT   = 3'd0,
    OP_DEL_MIN  = 3'd1,
    OP_DEL_AT   = 3'd2,
    OP_ADD_ONE  = 3'd3,
    OP_POOL_MIN = 3'd4,
    OP_SET_POOL = 3'd5,
    OP_LOCATE   = 3'd6
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_BAD   = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TGT,
    S_UP,
    S_LAST_RD,
    S_LAST,
    S_AO,
    S_DOWN,
    S_PM_RD,
    S_PM_SEG,
    S_PM_EV,
    S_LOC_MAP,
    S_LOC_HEAP,
    S_DONE
  } state_t;

  typedef struct packed {
    logic heap_re;
    pos_t heap_ra;
    logic heap_re1;
    pos_t heap_ra1;
    logic heap_we;
    pos_t heap_wa;
    ent_t heap_wd;
    logic map_re;
    seg_t map_ra;
    logic map_we;
    seg_t map_wa;
    pos_t map_wd;
    logic pool_re;
    seg_t pool_ra;
    logic pool_we;
    seg_t pool_wa;
    logic pool_wd;
  } mem_req_t;

  typedef struct packed {
    ent_t heap_rd;
    ent_t heap_rd1;
    pos_t map_rd;
    logic pool_rd;
  } mem_rsp_t;

  function automatic pos_t parent_of(input pos_t c);
    return pos_t'((c - 1'b1) >> 1);
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/ecmh_ram.sv
// Generic synchronous RAM, one write port and one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module ecmh_ram #(
  parameter int W = 8,
  parameter int D = 16,
  localparam int AW = $clog2(D)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [W-1:0]  wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [W-1:0]  rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/ecmh_ctrl.sv
// Heap controller: operation sequencer, sift up/down with a hole, pool and
// locate queries, result register. Depends on ecmh_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ecmh_ctrl import ecmh_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       clr_busy,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [2:0] in_operation,
  input  wire seg_t       in_segment_id,
  input  wire key_t       in_erase_count,
  input  wire logic       in_pool_value,
  input  wire pos_t       in_position,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [1:0]      out_status,
  output seg_t            out_result_segment,
  output key_t            out_result_count,
  output pos_t            out_result_position,
  output cnt_t            out_entry_total,
  output mem_req_t        req,
  input  wire mem_rsp_t   rsp
);

  state_t  state_r, state_nxt;
  cnt_t    cnt_r, cnt_nxt;
  op_t     op_r, op_nxt;
  seg_t    seg_r, seg_nxt;
  ent_t    mv_r, mv_nxt;
  pos_t    c_r, c_nxt;
  logic    swapped_r, swapped_nxt;
  seg_t    last_r, last_nxt;
  logic    force_r, force_nxt;
  logic    found_r, found_nxt;
  idx_t    idx_r, idx_nxt;
  status_t res_st_r, res_st_nxt;
  seg_t    res_seg_r, res_seg_nxt;
  key_t    res_key_r, res_key_nxt;
  pos_t    res_pos_r, res_pos_nxt;
  logic    out_valid_r, out_valid_nxt;
  status_t out_st_r, out_st_nxt;
  seg_t    out_seg_r, out_seg_nxt;
  key_t    out_key_r, out_key_nxt;
  pos_t    out_pos_r, out_pos_nxt;
  cnt_t    out_cnt_r, out_cnt_nxt;

  logic   in_acc, empty, full, pos_bad, out_free;
  logic   up_cont, sel_l, sel_r, down_cont, pm_stop, loc_bad;
  ent_t   rd0, rd1;
  key_t   key_m;
  child_t l_c, r_c, m_c;
  pos_t   m_p;

  assign rd0      = rsp.heap_rd;
  assign rd1      = rsp.heap_rd1;
  assign in_stall = (state_r != S_IDLE) || clr_busy;
  assign in_acc   = in_valid && !in_stall;
  assign empty    = (cnt_r == '0);
  assign full     = (cnt_r == CNT_FULL);
  assign pos_bad  = (cnt_t'(in_position) >= cnt_r);
  assign out_free = !out_valid_r || !out_stall;

  assign up_cont   = (c_r != '0) && ((op_r != OP_INSERT) || (rd0.key > mv_r.key));
  assign l_c       = {1'b0, c_r, 1'b1};
  assign r_c       = l_c + 1'b1;
  assign sel_l     = (l_c < child_t'(cnt_r)) && (rd0.key < mv_r.key);
  assign key_m     = sel_l ? rd0.key : mv_r.key;
  assign sel_r     = (r_c < child_t'(cnt_r)) && (rd1.key < key_m);
  assign down_cont = sel_l || sel_r;
  assign m_c       = sel_r ? r_c : l_c;
  assign m_p       = m_c[POS_W-1:0];
  assign pm_stop   = (cnt_t'(idx_r) >= cnt_r) || (idx_r == idx_t'(7)) ||
                     (((idx_r == idx_t'(1)) || (idx_r == idx_t'(3))) && found_r);
  assign loc_bad   = (cnt_t'(rsp.map_rd) >= cnt_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (op_t'(in_operation))
            OP_INSERT:   state_nxt = full ? S_DONE : S_UP;
            OP_DEL_MIN:  state_nxt = empty ? S_DONE : S_TGT;
            OP_DEL_AT:   state_nxt = (empty || pos_bad) ? S_DONE : S_TGT;
            OP_ADD_ONE:  state_nxt = (empty || pos_bad) ? S_DONE : S_AO;
            OP_POOL_MIN: state_nxt = empty ? S_DONE : S_PM_RD;
            OP_LOCATE:   state_nxt = S_LOC_MAP;
            default:     state_nxt = S_DONE;
          endcase
        end
      end
      S_TGT:      state_nxt = S_UP;
      S_UP:       state_nxt = up_cont ? S_UP : ((op_r == OP_INSERT) ? S_DONE : S_LAST_RD);
      S_LAST_RD:  state_nxt = S_LAST;
      S_LAST:     state_nxt = S_DOWN;
      S_AO:       state_nxt = S_DOWN;
      S_DOWN:     state_nxt = down_cont ? S_DOWN : S_DONE;
      S_PM_RD:    state_nxt = pm_stop ? S_DONE : S_PM_SEG;
      S_PM_SEG:   state_nxt = S_PM_EV;
      S_PM_EV:    state_nxt = S_PM_RD;
      S_LOC_MAP:  state_nxt = loc_bad ? S_DONE : S_LOC_HEAP;
      S_LOC_HEAP: state_nxt = S_DONE;
      S_DONE:     state_nxt = out_free ? S_IDLE : S_DONE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    pos_t tgt;
    tgt           = '0;
    req           = '0;
    cnt_nxt       = cnt_r;
    op_nxt        = op_r;
    seg_nxt       = seg_r;
    mv_nxt        = mv_r;
    c_nxt         = c_r;
    swapped_nxt   = swapped_r;
    last_nxt      = last_r;
    force_nxt     = force_r;
    found_nxt     = found_r;
    idx_nxt       = idx_r;
    res_st_nxt    = res_st_r;
    res_seg_nxt   = res_seg_r;
    res_key_nxt   = res_key_r;
    res_pos_nxt   = res_pos_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_st_nxt    = out_st_r;
    out_seg_nxt   = out_seg_r;
    out_key_nxt   = out_key_r;
    out_pos_nxt   = out_pos_r;
    out_cnt_nxt   = out_cnt_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          op_nxt      = op_t'(in_operation);
          seg_nxt     = in_segment_id;
          swapped_nxt = 1'b0;
          force_nxt   = 1'b0;
          found_nxt   = 1'b0;
          idx_nxt     = '0;
          res_st_nxt  = ST_OK;
          res_seg_nxt = '0;
          res_key_nxt = '0;
          res_pos_nxt = '0;
          case (op_t'(in_operation))
            OP_INSERT: begin
              if (full) begin
                res_st_nxt = ST_FULL;
              end else begin
                cnt_nxt     = cnt_r + 1'b1;
                mv_nxt      = '{seg: in_segment_id, key: in_erase_count};
                c_nxt       = pos_t'(cnt_r);
                req.heap_re = 1'b1;
                req.heap_ra = parent_of(pos_t'(cnt_r));
              end
            end
            OP_DEL_MIN, OP_DEL_AT: begin
              tgt = (op_t'(in_operation) == OP_DEL_AT) ? in_position : '0;
              if (empty) begin
                res_st_nxt = ST_EMPTY;
              end else if ((op_t'(in_operation) == OP_DEL_AT) && pos_bad) begin
                res_st_nxt = ST_BAD;
              end else begin
                c_nxt       = tgt;
                res_pos_nxt = tgt;
                req.heap_re = 1'b1;
                req.heap_ra = tgt;
              end
            end
            OP_ADD_ONE: begin
              if (empty) begin
                res_st_nxt = ST_EMPTY;
              end else if (pos_bad) begin
                res_st_nxt = ST_BAD;
              end else begin
                c_nxt       = in_position;
                req.heap_re = 1'b1;
                req.heap_ra = in_position;
              end
            end
            OP_POOL_MIN: begin
              if (empty) begin
                res_st_nxt = ST_EMPTY;
              end
            end
            OP_SET_POOL: begin
              req.pool_we = 1'b1;
              req.pool_wa = in_segment_id;
              req.pool_wd = in_pool_value;
              res_seg_nxt = in_segment_id;
            end
            OP_LOCATE: begin
              req.map_re  = 1'b1;
              req.map_ra  = in_segment_id;
              res_seg_nxt = in_segment_id;
            end
            default: begin
              res_st_nxt = ST_BAD;
            end
          endcase
        end
      end
      S_TGT: begin
        mv_nxt      = rd0;
        res_seg_nxt = rd0.seg;
        res_key_nxt = rd0.key;
        req.heap_re = 1'b1;
        req.heap_ra = parent_of(c_r);
      end
      S_UP: begin
        if (up_cont) begin
          req.heap_we = 1'b1;
          req.heap_wa = c_r;
          req.heap_wd = rd0;
          req.map_we  = 1'b1;
          req.map_wa  = rd0.seg;
          req.map_wd  = c_r;
          last_nxt    = rd0.seg;
          swapped_nxt = 1'b1;
          c_nxt       = parent_of(c_r);
          req.heap_re = 1'b1;
          req.heap_ra = parent_of(parent_of(c_r));
        end else if (op_r == OP_INSERT) begin
          req.heap_we = 1'b1;
          req.heap_wa = c_r;
          req.heap_wd = mv_r;
          req.map_we  = !(swapped_r && (last_r == mv_r.seg));
          req.map_wa  = mv_r.seg;
          req.map_wd  = c_r;
          res_seg_nxt = mv_r.seg;
          res_key_nxt = mv_r.key;
          res_pos_nxt = c_r;
        end else begin
          req.map_we  = swapped_r && (last_r != mv_r.seg);
          req.map_wa  = mv_r.seg;
          req.map_wd  = c_r;
        end
      end
      S_LAST_RD: begin
        req.heap_re = 1'b1;
        req.heap_ra = pos_t'(cnt_r - 1'b1);
      end
      S_LAST: begin
        mv_nxt       = rd0;
        cnt_nxt      = cnt_r - 1'b1;
        c_nxt        = '0;
        force_nxt    = 1'b1;
        swapped_nxt  = 1'b0;
        req.heap_re  = 1'b1;
        req.heap_ra  = pos_t'(1);
        req.heap_re1 = 1'b1;
        req.heap_ra1 = pos_t'(2);
      end
      S_AO: begin
        mv_nxt.seg   = rd0.seg;
        mv_nxt.key   = (rd0.key == KEY_MAX) ? rd0.key : rd0.key + 1'b1;
        swapped_nxt  = 1'b0;
        force_nxt    = 1'b0;
        req.heap_re  = 1'b1;
        req.heap_ra  = l_c[POS_W-1:0];
        req.heap_re1 = 1'b1;
        req.heap_ra1 = r_c[POS_W-1:0];
      end
      S_DOWN: begin
        if (down_cont) begin
          req.heap_we  = 1'b1;
          req.heap_wa  = c_r;
          req.heap_wd  = sel_r ? rd1 : rd0;
          req.map_we   = 1'b1;
          req.map_wa   = sel_r ? rd1.seg : rd0.seg;
          req.map_wd   = c_r;
          swapped_nxt  = 1'b1;
          c_nxt        = m_p;
          req.heap_re  = 1'b1;
          req.heap_ra  = pos_t'({m_p, 1'b1});
          req.heap_re1 = 1'b1;
          req.heap_ra1 = pos_t'({m_p, 1'b1} + 1'b1);
        end else begin
          req.heap_we = 1'b1;
          req.heap_wa = c_r;
          req.heap_wd = mv_r;
          req.map_we  = force_r || swapped_r;
          req.map_wa  = mv_r.seg;
          req.map_wd  = c_r;
          if (op_r == OP_ADD_ONE) begin
            res_seg_nxt = mv_r.seg;
            res_key_nxt = mv_r.key;
            res_pos_nxt = c_r;
          end
        end
      end
      S_PM_RD: begin
        if (pm_stop) begin
          res_st_nxt = found_r ? ST_OK : ST_BAD;
        end else begin
          req.heap_re = 1'b1;
          req.heap_ra = pos_t'(idx_r);
        end
      end
      S_PM_SEG: begin
        mv_nxt      = rd0;
        req.pool_re = 1'b1;
        req.pool_ra = rd0.seg;
      end
      S_PM_EV: begin
        if (rsp.pool_rd && (!found_r || (mv_r.key < res_key_r))) begin
          found_nxt   = 1'b1;
          res_seg_nxt = mv_r.seg;
          res_key_nxt = mv_r.key;
          res_pos_nxt = pos_t'(idx_r);
        end
        idx_nxt = idx_r + 1'b1;
      end
      S_LOC_MAP: begin
        c_nxt = rsp.map_rd;
        if (loc_bad) begin
          res_st_nxt = ST_BAD;
        end else begin
          req.heap_re = 1'b1;
          req.heap_ra = rsp.map_rd;
        end
      end
      S_LOC_HEAP: begin
        if (rd0.seg == seg_r) begin
          res_key_nxt = rd0.key;
          res_pos_nxt = c_r;
        end else begin
          res_st_nxt = ST_BAD;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_st_nxt    = res_st_r;
          out_seg_nxt   = res_seg_r;
          out_key_nxt   = res_key_r;
          out_pos_nxt   = res_pos_r;
          out_cnt_nxt   = cnt_r;
        end
      end
      default: begin
        req = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    seg_r     <= seg_nxt;
    mv_r      <= mv_nxt;
    c_r       <= c_nxt;
    swapped_r <= swapped_nxt;
    last_r    <= last_nxt;
    force_r   <= force_nxt;
    found_r   <= found_nxt;
    idx_r     <= idx_nxt;
    res_st_r  <= res_st_nxt;
    res_seg_r <= res_seg_nxt;
    res_key_r <= res_key_nxt;
    res_pos_r <= res_pos_nxt;
    out_st_r  <= out_st_nxt;
    out_seg_r <= out_seg_nxt;
    out_key_r <= out_key_nxt;
    out_pos_r <= out_pos_nxt;
    out_cnt_r <= out_cnt_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_st_r;
  assign out_result_segment  = out_seg_r;
  assign out_result_count    = out_key_r;
  assign out_result_position = out_pos_r;
  assign out_entry_total     = out_cnt_r;

  a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_FULL)
    else $error("entry count above capacity");

  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (cnt_r == $past(cnt_r)) || (cnt_r == $past(cnt_r) + 1'b1) ||
                     (cnt_r == $past(cnt_r) - 1'b1))
    else $error("entry count jumped");

  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_DONE)
    else $error("result loaded outside completion");

  a_idle_nowr: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !req.heap_we)
    else $error("heap written while idle");

endmodule

`default_nettype wire

>>> hw/rtl/erase_count_min_heap_core.sv
// Top level of the erase-count min-heap: heap, position map and pool flag
// memories, pool clearing pass. Depends on ecmh_pkg, ecmh_ram, ecmh_ctrl.
//
//  channel | ports                                   | direction
//  input   | in_valid/in_stall, in_operation..       | item in, stall out
//  result  | out_valid/out_stall, out_status..       | item out, stall in
//
// One item at a time. Insert sifts up; delete moves the hole to the root, then
// sifts the last entry down; add one sifts down; each level reads and writes
// heap memory. Pool min scans at most seven slots; locate reads map, then heap.
// After reset the pool flags are cleared, one per cycle, while input stalls.
// A finished result waits in the output register while the next item enters.
`timescale 1ns / 1ps
`default_nettype none

module erase_count_min_heap_core import ecmh_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [2:0] in_operation,
  input  wire seg_t       in_segment_id,
  input  wire key_t       in_erase_count,
  input  wire logic       in_pool_value,
  input  wire pos_t       in_position,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [1:0]      out_status,
  output seg_t            out_result_segment,
  output key_t            out_result_count,
  output pos_t            out_result_position,
  output cnt_t            out_entry_total
);

  mem_req_t req;
  mem_rsp_t rsp;
  ent_t     heap_rd0, heap_rd1;
  pos_t     map_rd;
  logic     pool_rd;
  logic     clr_busy_r, clr_busy_nxt;
  seg_t     clr_idx_r, clr_idx_nxt;
  logic     pool_we;
  seg_t     pool_wa;
  logic     pool_wd;

  always_comb begin
    clr_busy_nxt = clr_busy_r;
    clr_idx_nxt  = clr_idx_r;
    if (clr_busy_r) begin
      clr_idx_nxt = clr_idx_r + 1'b1;
      if (clr_idx_r == seg_t'(SEGS - 1)) begin
        clr_busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_idx_r  <= '0;
    end else begin
      clr_busy_r <= clr_busy_nxt;
      clr_idx_r  <= clr_idx_nxt;
    end
  end

  assign pool_we = clr_busy_r || req.pool_we;
  assign pool_wa = clr_busy_r ? clr_idx_r : req.pool_wa;
  assign pool_wd = clr_busy_r ? 1'b0 : req.pool_wd;

  assign rsp = '{heap_rd: heap_rd0, heap_rd1: heap_rd1, map_rd: map_rd, pool_rd: pool_rd};

  ecmh_ram #(.W(ENT_W), .D(CAP)) u_heap0 (
    .clk   (clk),
    .we    (req.heap_we),
    .waddr (req.heap_wa),
    .wdata (req.heap_wd),
    .re    (req.heap_re),
    .raddr (req.heap_ra),
    .rdata (heap_rd0)
  );

  ecmh_ram #(.W(ENT_W), .D(CAP)) u_heap1 (
    .clk   (clk),
    .we    (req.heap_we),
    .waddr (req.heap_wa),
    .wdata (req.heap_wd),
    .re    (req.heap_re1),
    .raddr (req.heap_ra1),
    .rdata (heap_rd1)
  );

  ecmh_ram #(.W(POS_W), .D(SEGS)) u_map (
    .clk   (clk),
    .we    (req.map_we),
    .waddr (req.map_wa),
    .wdata (req.map_wd),
    .re    (req.map_re),
    .raddr (req.map_ra),
    .rdata (map_rd)
  );

  ecmh_ram #(.W(1), .D(SEGS)) u_pool (
    .clk   (clk),
    .we    (pool_we),
    .waddr (pool_wa),
    .wdata (pool_wd),
    .re    (req.pool_re),
    .raddr (req.pool_ra),
    .rdata (pool_rd)
  );

  ecmh_ctrl u_ctrl (
    .clk                 (clk),
    .rst_n               (rst_n),
    .clr_busy            (clr_busy_r),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_operation        (in_operation),
    .in_segment_id       (in_segment_id),
    .in_erase_count      (in_erase_count),
    .in_pool_value       (in_pool_value),
    .in_position         (in_position),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_result_segment  (out_result_segment),
    .out_result_count    (out_result_count),
    .out_result_position (out_result_position),
    .out_entry_total     (out_entry_total),
    .req                 (req),
    .rsp                 (rsp)
  );

endmodule

`default_nettype wire

>>> dv/tb_erase_count_min_heap_core.sv
// Testbench for erase_count_min_heap_core: drives heap operations, predicts
// every result with a behavioral heap model and compares field by field.
// Depends on ecmh_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_erase_count_min_heap_core;
  import ecmh_pkg::*;

  typedef struct packed {
    logic [2:0] op;
    seg_t seg;
    key_t key;
    logic pv;
    pos_t pos;
  } heap_cmd_t;

  typedef struct packed {
    logic [1:0] status;
    seg_t seg;
    key_t key;
    pos_t pos;
    cnt_t total;
  } heap_rsp_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] in_operation = '0;
  seg_t in_segment_id = '0;
  key_t in_erase_count = '0;
  logic in_pool_value = 1'b0;
  pos_t in_position = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_status;
  seg_t out_result_segment;
  key_t out_result_count;
  pos_t out_result_position;
  cnt_t out_entry_total;

  erase_count_min_heap_core u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_operation(in_operation), .in_segment_id(in_segment_id),
    .in_erase_count(in_erase_count), .in_pool_value(in_pool_value),
    .in_position(in_position),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_status(out_status), .out_result_segment(out_result_segment),
    .out_result_count(out_result_count),
    .out_result_position(out_result_position),
    .out_entry_total(out_entry_total)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // shadow heap
  seg_t sh_seg [CAP];
  key_t sh_key [CAP];
  pos_t sh_map [SEGS];
  logic sh_pool [SEGS];
  int unsigned sh_count;

  // segments that have been inserted at least once; only those are located
  bit seen [SEGS];

  heap_cmd_t cmd_q[$];
  heap_rsp_t expected_q[$];
  int errors = 0;
  int unsigned cycles = 0;
  bit quiet = 0;
  int in_gap = 0;
  int out_gap = 0;
  logic in_stall_q = 1'b0;
  bit hold_send = 0;

  function automatic void swap_slots(int unsigned a, int unsigned b);
    seg_t s;
    key_t k;
    s = sh_seg[a]; k = sh_key[a];
    sh_seg[a] = sh_seg[b]; sh_key[a] = sh_key[b];
    sh_seg[b] = s; sh_key[b] = k;
    sh_map[sh_seg[a]] = pos_t'(a);
    sh_map[sh_seg[b]] = pos_t'(b);
  endfunction

  function automatic int unsigned sift_down(int unsigned i);
    int unsigned l, r, m;
    while (sh_count > 1) begin
      l = 2 * i + 1; r = 2 * i + 2; m = i;
      if (l < sh_count && sh_key[l] < sh_key[i]) m = l;
      if (r < sh_count && sh_key[r] < sh_key[m]) m = r;
      if (m == i) break;
      swap_slots(i, m);
      i = m;
    end
    return i;
  endfunction

  function automatic heap_rsp_t mk(status_t st, seg_t s, key_t k, pos_t p);
    heap_rsp_t r;
    r.status = st; r.seg = s; r.key = k; r.pos = p; r.total = cnt_t'(sh_count);
    return r;
  endfunction

  function automatic heap_rsp_t heap_apply(heap_cmd_t c);
    int unsigned i, lo, hi, best, cur;
    bit found;
    seg_t rs;
    key_t rk;
    pos_t p;
    case (c.op)
      OP_INSERT: begin
        if (sh_count >= CAP) return mk(ST_FULL, '0, '0, '0);
        cur = sh_count;
        sh_count++;
        sh_seg[cur] = c.seg; sh_key[cur] = c.key; sh_map[c.seg] = pos_t'(cur);
        while (cur > 0 && sh_key[(cur - 1) / 2] > sh_key[cur]) begin
          swap_slots((cur - 1) / 2, cur);
          cur = (cur - 1) / 2;
        end
        return mk(ST_OK, c.seg, c.key, pos_t'(cur));
      end
      OP_DEL_MIN, OP_DEL_AT: begin
        if (sh_count == 0) return mk(ST_EMPTY, '0, '0, '0);
        cur = (c.op == OP_DEL_MIN) ? 0 : c.pos;
        if (cur >= sh_count) return mk(ST_BAD, '0, '0, '0);
        rs = sh_seg[cur]; rk = sh_key[cur];
        while (cur > 0) begin
          swap_slots((cur - 1) / 2, cur);
          cur = (cur - 1) / 2;
        end
        sh_seg[0] = sh_seg[sh_count - 1];
        sh_key[0] = sh_key[sh_count - 1];
        sh_map[sh_seg[0]] = '0;
        sh_count--;
        void'(sift_down(0));
        return mk(ST_OK, rs, rk, (c.op == OP_DEL_MIN) ? pos_t'(0) : c.pos);
      end
      OP_ADD_ONE: begin
        if (sh_count == 0) return mk(ST_EMPTY, '0, '0, '0);
        if (c.pos >= sh_count) return mk(ST_BAD, '0, '0, '0);
        if (sh_key[c.pos] != KEY_MAX) sh_key[c.pos]++;
        cur = sift_down(c.pos);
        return mk(ST_OK, sh_seg[cur], sh_key[cur], pos_t'(cur));
      end
      OP_POOL_MIN: begin
        if (sh_count == 0) return mk(ST_EMPTY, '0, '0, '0);
        found = 0; best = 0; lo = 0; hi = 0;
        while (lo <= 6 && !found) begin
          for (i = lo; i <= hi && i < sh_count; i++)
            if (sh_pool[sh_seg[i]] && (!found || sh_key[i] < sh_key[best])) begin
              best = i; found = 1;
            end
          lo = 2 * lo + 1; hi = 2 * hi + 2;
        end
        if (!found) return mk(ST_BAD, '0, '0, '0);
        return mk(ST_OK, sh_seg[best], sh_key[best], pos_t'(best));
      end
      OP_SET_POOL: begin
        sh_pool[c.seg] = c.pv;
        return mk(ST_OK, c.seg, '0, '0);
      end
      OP_LOCATE: begin
        p = sh_map[c.seg];
        if (p >= sh_count || sh_seg[p] != c.seg) return mk(ST_BAD, c.seg, '0, '0);
        return mk(ST_OK, c.seg, sh_key[p], p);
      end
      default: return mk(ST_BAD, '0, '0, '0);
    endcase
  endfunction

  // random positions; occasionally beyond the fill
  function automatic pos_t pick_pos();
    if (sh_count > 0 && $urandom_range(0, 9) != 0)
      return pos_t'($urandom_range(0, sh_count - 1));
    return pos_t'($urandom);
  endfunction

  function automatic heap_cmd_t mk_cmd(logic [2:0] op, seg_t s, key_t k, logic pv, pos_t p);
    heap_cmd_t c;
    c.op = op; c.seg = s; c.key = k; c.pv = pv; c.pos = p;
    return c;
  endfunction

  // driver
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall_q) begin
        if (cmd_q.size() > 0 && !hold_send &&
            !(in_gap == 0 && !quiet && $urandom_range(0, 7) == 0)) begin
          in_operation <= cmd_q[0].op; in_segment_id <= cmd_q[0].seg;
          in_erase_count <= cmd_q[0].key; in_pool_value <= cmd_q[0].pv;
          in_position <= cmd_q[0].pos;
          void'(cmd_q.pop_front());
        end else begin
          in_valid <= 1'b0;
          if (!quiet && cmd_q.size() > 0 && !hold_send) in_gap = $urandom_range(1, 10);
        end
      end else if (!in_valid) begin
        if (in_gap > 0) in_gap--;
        else if (cmd_q.size() > 0 && !hold_send) begin
          in_valid <= 1'b1;
          in_operation <= cmd_q[0].op; in_segment_id <= cmd_q[0].seg;
          in_erase_count <= cmd_q[0].key; in_pool_value <= cmd_q[0].pv;
          in_position <= cmd_q[0].pos;
          void'(cmd_q.pop_front());
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        if (out_gap == 0) out_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 15) == 0) begin
        out_stall <= 1'b1;
        out_gap = $urandom_range(1, 10);
      end
    end
  end

  // acceptance sampled at posedge
  heap_cmd_t sent;
  heap_rsp_t exp_r, got;
  always @(posedge clk) begin
    in_stall_q <= in_stall;
    if (rst_n) begin
      cycles++;
      if (in_valid && !in_stall) begin
        sent.op = in_operation; sent.seg = in_segment_id; sent.key = in_erase_count;
        sent.pv = in_pool_value; sent.pos = in_position;
        expected_q.push_back(heap_apply(sent));
      end
      if (out_valid && !out_stall) begin
        got.status = out_status; got.seg = out_result_segment; got.key = out_result_count;
        got.pos = out_result_position; got.total = out_entry_total;
        if (expected_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result %h", got);
        end else begin
          exp_r = expected_q.pop_front();
          if (exp_r !== got) begin
            errors++;
            if (errors <= 10)
              $display({"mismatch: exp st=%0d seg=%0d key=%0d pos=%0d n=%0d",
                        " got st=%0d seg=%0d key=%0d pos=%0d n=%0d"},
                exp_r.status, exp_r.seg, exp_r.key, exp_r.pos, exp_r.total,
                got.status, got.seg, got.key, got.pos, got.total);
          end
        end
      end
      if (cycles > 600000) begin
        $display("tb_erase_count_min_heap_core: done, errors");
        $finish;
      end
    end
  end

  // stimulus
  int unsigned fill, n, k;
  heap_cmd_t c;
  logic [2:0] op;
  initial begin
    for (int s = 0; s < SEGS; s++) sh_pool[s] = 1'b0;
    sh_count = 0;
    seen[1023] = 1'b1;
    seen[0] = 1'b1;
    seen[5] = 1'b1;
    repeat (11) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // directed: empty-heap corners, extremes, saturation, pool, locate, bad op
    cmd_q.push_back(mk_cmd(OP_DEL_MIN, '0, '0, 0, '0));
    cmd_q.push_back(mk_cmd(OP_DEL_AT, '0, '0, 0, '0));
    cmd_q.push_back(mk_cmd(OP_ADD_ONE, '0, '0, 0, '0));
    cmd_q.push_back(mk_cmd(OP_POOL_MIN, '0, '0, 0, '0));
    cmd_q.push_back(mk_cmd(3'd7, '1, '1, 1, '1));
    cmd_q.push_back(mk_cmd(OP_INSERT, '1, KEY_MAX, 0, '0));
    cmd_q.push_back(mk_cmd(OP_LOCATE, '1, '0, 0, '0));
    cmd_q.push_back(mk_cmd(OP_ADD_ONE, '0, '0, 0, '0));
    cmd_q.push_back(mk_cmd(OP_INSERT, '0, '0, 0, '1));
    cmd_q.push_back(mk_cmd(OP_INSERT, 10'd5, 24'd7, 0, '0));
    cmd_q.push_back(mk_cmd(OP_INSERT, 10'd5, 24'd3, 0, '0));
    cmd_q.push_back(mk_cmd(OP_LOCATE, 10'd5, '0, 0, '0));
    cmd_q.push_back(mk_cmd(OP_POOL_MIN, '0, '0, 0, '0));
    cmd_q.push_back(mk_cmd(OP_SET_POOL, '1, '0, 1, '0));
    cmd_q.push_back(mk_cmd(OP_SET_POOL, 10'd5, '0, 1, '0));
    cmd_q.push_back(mk_cmd(OP_POOL_MIN, '0, '0, 0, '0));
    cmd_q.push_back(mk_cmd(OP_DEL_AT, '0, '0, 0, 10'd9));
    cmd_q.push_back(mk_cmd(OP_ADD_ONE, '0, '0, 0, '1));
    cmd_q.push_back(mk_cmd(OP_DEL_AT, '0, '0, 0, 10'd3));
    cmd_q.push_back(mk_cmd(OP_DEL_MIN, '0, '0, 0, '0));
    cmd_q.push_back(mk_cmd(OP_LOCATE, '0, '0, 0, '0));
    cmd_q.push_back(mk_cmd(OP_SET_POOL, 10'd5, '0, 0, '0));

    // pause until every result is back
    wait (cmd_q.size() == 0 && !in_valid);
    hold_send = 1;
    wait (expected_q.size() == 0);
    hold_send = 0;

    // grow the heap, flag some segments, then shrink it again
    for (int i = 0; i < 60; i++) begin
      c = mk_cmd(OP_INSERT, seg_t'($urandom), key_t'($urandom_range(0, 255)), 0, '0);
      seen[c.seg] = 1'b1;
      cmd_q.push_back(c);
    end
    for (int i = 0; i < 12; i++)
      cmd_q.push_back(mk_cmd(OP_SET_POOL, seg_t'($urandom), '0, 1'($urandom), '0));
    for (int i = 0; i < 40; i++)
      cmd_q.push_back(mk_cmd((i % 3 == 0) ? OP_DEL_AT : OP_DEL_MIN, '0, '0, 0,
                             pos_t'($urandom_range(0, 60))));

    // random mix; positions use an estimated fill
    fill = 20;
    for (int i = 0; i < 270; i++) begin
      k = $urandom_range(0, 99);
      if (k < 30) op = OP_INSERT;
      else if (k < 40) op = OP_DEL_MIN;
      else if (k < 50) op = OP_DEL_AT;
      else if (k < 65) op = OP_ADD_ONE;
      else if (k < 75) op = OP_POOL_MIN;
      else if (k < 85) op = OP_SET_POOL;
      else if (k < 98) op = OP_LOCATE;
      else op = 3'd7;
      n = $urandom_range(0, 3);
      c = mk_cmd(op, seg_t'($urandom_range(0, 63)),
                 (n == 0) ? key_t'($urandom) : key_t'($urandom_range(0, 40)),
                 1'($urandom),
                 ($urandom_range(0, 9) == 0) ? pos_t'($urandom)
                                            : pos_t'($urandom_range(0, fill + 2)));
      if (n == 3) c.seg = seg_t'($urandom);
      if (op == OP_LOCATE && !seen[c.seg]) c.seg = 10'd5;
      if (op == OP_INSERT) seen[c.seg] = 1'b1;
      if (op == OP_INSERT) fill++;
      if ((op == OP_DEL_MIN || op == OP_DEL_AT) && fill > 0) fill--;
      if (i == 210) begin
        wait (cmd_q.size() == 0);
        quiet = 1;
      end
      cmd_q.push_back(c);
    end

    wait (cmd_q.size() == 0 && !in_valid);
    wait (expected_q.size() == 0);
    repeat (40) @(posedge clk);
    if (errors == 0 && expected_q.size() == 0)
      $display("tb_erase_count_min_heap_core: done, clean");
    else
      $display("tb_erase_count_min_heap_core: done, errors");
    $finish;
  end
endmodule

>>> filelist.f
hw/rtl/ecmh_pkg.sv
hw/rtl/ecmh_ram.sv
hw/rtl/ecmh_ctrl.sv
hw/rtl/erase_count_min_heap_core.sv
dv/tb_erase_count_min_heap_core.sv
